FILE: src/ebalu_pkg.sv
// Package: beat types, operation codes and flag positions for the eight-bit ALU.
package ebalu_pkg;

	// Operation codes
	localparam logic [4:0] OP_ADD   = 5'd0;
	localparam logic [4:0] OP_ADC   = 5'd1;
	localparam logic [4:0] OP_SUB   = 5'd2;
	localparam logic [4:0] OP_SBC   = 5'd3;
	localparam logic [4:0] OP_AND   = 5'd4;
	localparam logic [4:0] OP_XOR   = 5'd5;
	localparam logic [4:0] OP_OR    = 5'd6;
	localparam logic [4:0] OP_CP    = 5'd7;
	localparam logic [4:0] OP_INC   = 5'd8;
	localparam logic [4:0] OP_DEC   = 5'd9;
	localparam logic [4:0] OP_ADD16 = 5'd10;
	localparam logic [4:0] OP_DAA   = 5'd11;
	localparam logic [4:0] OP_RLC   = 5'd12;
	localparam logic [4:0] OP_RRC   = 5'd13;
	localparam logic [4:0] OP_RL    = 5'd14;
	localparam logic [4:0] OP_RR    = 5'd15;
	localparam logic [4:0] OP_SLA   = 5'd16;
	localparam logic [4:0] OP_SRA   = 5'd17;
	localparam logic [4:0] OP_SRL   = 5'd18;
	localparam logic [4:0] OP_SWAP  = 5'd19;
	localparam logic [4:0] OP_BIT   = 5'd20;
	localparam logic [4:0] OP_SET   = 5'd21;
	localparam logic [4:0] OP_RES   = 5'd22;
	localparam logic [4:0] OP_RLCA  = 5'd23;
	localparam logic [4:0] OP_RRCA  = 5'd24;
	localparam logic [4:0] OP_RLA   = 5'd25;
	localparam logic [4:0] OP_RRA   = 5'd26;

	// Flag bit positions
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	// BCD correction constants
	localparam logic [7:0] DAA_HI = 8'h60;
	localparam logic [7:0] DAA_LO = 8'h06;
	localparam logic [7:0] DAA_MAX = 8'h99;
	localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;

	typedef struct packed {
		logic [4:0]  func;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [2:0]  bit_index;
		logic [3:0]  flags_in;
	} req_t;

	typedef struct packed {
		logic [15:0] result;
		logic [3:0]  flags_out;
	} rsp_t;

endpackage

FILE: src/ebalu_core.sv
// ALU datapath: one operation, result and new flags, combinational.
module ebalu_core import ebalu_pkg::*; (
	input  req_t req,
	output rsp_t rsp
);

	always_comb begin
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  r;
		logic [7:0]  v;
		logic        cin;
		logic        cy;
		logic        dc;
		logic [8:0]  s9;
		logic [4:0]  h5;
		logic [9:0]  d10;
		logic [16:0] s17;
		logic [12:0] h13;
		logic [15:0] wide;
		logic        use_wide;
		logic [3:0]  f;

		a        = req.operand_a[7:0];
		b        = req.operand_b[7:0];
		cin      = req.flags_in[FLAG_C];
		r        = 8'h00;
		v        = a;
		cy       = 1'b0;
		dc       = cin;
		s9       = 9'd0;
		h5       = 5'd0;
		d10      = 10'd0;
		s17      = 17'd0;
		h13      = 13'd0;
		wide     = req.operand_a;
		use_wide = 1'b0;
		f        = 4'h0;

		case (req.func) inside
			OP_ADD, OP_ADC: begin
				cy = (req.func == OP_ADC) ? cin : 1'b0;
				s9 = {1'b0, a} + {1'b0, b} + {8'd0, cy};
				h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
				r  = s9[7:0];
				f  = {1'b0, 1'b0, h5[4], s9[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				cy  = (req.func == OP_SBC) ? cin : 1'b0;
				d10 = {2'b0, a} - {2'b0, b} - {9'd0, cy};
				h5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};
				r   = (req.func == OP_CP) ? a : d10[7:0];
				f   = {d10[7:0] == 8'h00, 1'b1, h5[4], d10[9]};
			end
			OP_AND: begin
				r = a & b;
				f = 4'b0010;
			end
			OP_XOR: r = a ^ b;
			OP_OR:  r = a | b;
			OP_INC: begin
				r = a + 8'd1;
				f = {1'b0, 1'b0, a[3:0] == 4'hF, cin};
			end
			OP_DEC: begin
				r = a - 8'd1;
				f = {1'b0, 1'b1, a[3:0] == 4'h0, cin};
			end
			OP_ADD16: begin
				s17      = {1'b0, req.operand_a} + {1'b0, req.operand_b};
				h13      = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
				wide     = s17[15:0];
				use_wide = 1'b1;
				f        = {req.flags_in[FLAG_Z], 1'b0, h13[12], s17[16]};
			end
			OP_DAA: begin
				if (!req.flags_in[FLAG_N]) begin
					if (cin || a > DAA_MAX) begin
						v  = v + DAA_HI;
						dc = 1'b1;
					end
					if (req.flags_in[FLAG_H] || v[3:0] > DAA_DIGIT_MAX)
						v = v + DAA_LO;
				end else begin
					if (cin)
						v = v - DAA_HI;
					if (req.flags_in[FLAG_H])
						v = v - DAA_LO;
				end
				r = v;
				f = {1'b0, req.flags_in[FLAG_N], 1'b0, dc};
			end
			OP_RLC, OP_RLCA: begin
				r = {a[6:0], a[7]};
				f = {3'b000, a[7]};
			end
			OP_RRC, OP_RRCA: begin
				r = {a[0], a[7:1]};
				f = {3'b000, a[0]};
			end
			OP_RL, OP_RLA: begin
				r = {a[6:0], cin};
				f = {3'b000, a[7]};
			end
			OP_RR, OP_RRA: begin
				r = {cin, a[7:1]};
				f = {3'b000, a[0]};
			end
			OP_SLA: begin
				r = {a[6:0], 1'b0};
				f = {3'b000, a[7]};
			end
			OP_SRA: begin
				r = {a[7], a[7:1]};
				f = {3'b000, a[0]};
			end
			OP_SRL: begin
				r = {1'b0, a[7:1]};
				f = {3'b000, a[0]};
			end
			OP_SWAP: r = {a[3:0], a[7:4]};
			OP_BIT: begin
				r = a;
				f = {!a[req.bit_index], 1'b0, 1'b1, cin};
			end
			OP_SET: begin
				r = a | (8'd1 << req.bit_index);
				f = req.flags_in;
			end
			OP_RES: begin
				r = a & ~(8'd1 << req.bit_index);
				f = req.flags_in;
			end
			default: begin
				// unused codes: operand and flags pass through
				wide     = req.operand_a;
				use_wide = 1'b1;
				f        = req.flags_in;
			end
		endcase

		// Z from the 8-bit result for the ops that define it that way
		case (req.func) inside
			OP_ADD, OP_ADC, OP_AND, OP_XOR, OP_OR, OP_INC, OP_DEC, OP_DAA,
			OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL, OP_SWAP:
				f[FLAG_Z] = (r == 8'h00);
			default: ;
		endcase

		rsp.result    = use_wide ? wide : {8'h00, r};
		rsp.flags_out = f;
	end

endmodule

FILE: src/eight_bit_alu_with_flags.sv
// Top level: registered eight-bit ALU with Z N H C flags.
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  req      in         start && !busy       func, operand_a, operand_b,
//                                           bit_index, flags_in (req_t)
//  rsp      out        done (one cycle)     result, flags_out (rsp_t)
//
// Flow: one beat per clock sustained; a command beat is held in the input register,
// passes once through the ALU core and is strobed from the result register.
// busy is held low, so a command can be issued every cycle.
// Reset: arst_n clears the stage valid bits; no result strobe follows reset
// until a command is taken. Stalls: none, the receiver takes every result
// in the cycle it is strobed.
module eight_bit_alu_with_flags import ebalu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	// stage 1: command register
	req_t req_s1;
	logic vld_s1;
	// stage 2: result register
	rsp_t rsp_s2;
	logic vld_s2;
	logic [4:0] func_s2;

	rsp_t core_rsp;

	// the pipeline never backs up, so commands are always taken
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (start && !busy)
			req_s1 <= req;
		if (vld_s1) begin
			rsp_s2  <= core_rsp;
			func_s2 <= req_s1.func;
		end
	end

	ebalu_core u_core (
		.req (req_s1),
		.rsp (core_rsp)
	);

	assign done = vld_s2;
	assign rsp  = rsp_s2;

`ifndef ASSERT_OFF
	// every command beat yields a result beat from the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result beat missing two cycles after command");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> vld_s1 == 1'b0 || vld_s1 == 1'b1 ? $past(vld_s1) : 1'b0)
		else $error("result beat without a command");

	// only add16 and unused codes may put anything in the upper byte
	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && func_s2 != OP_ADD16 && func_s2 <= OP_RRA) |-> rsp.result[15:8] == 8'h00)
		else $error("8-bit operation drove the upper result byte");

	// subtract-class ops always set N
	a_sub_n: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (func_s2 == OP_SUB || func_s2 == OP_SBC || func_s2 == OP_CP ||
			func_s2 == OP_DEC)) |-> rsp.flags_out[FLAG_N])
		else $error("subtract-class operation left N clear");
`endif

endmodule

FILE: tb/eight_bit_alu_with_flags_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the eight-bit ALU: directed, random and full-rate beats.
module eight_bit_alu_with_flags_tb;
	import ebalu_pkg::*;

	// codes past the last defined operation; the block passes operand_a and flags through
	localparam logic [4:0] OP_UNUSED_LOW = 5'd27;
	localparam logic [4:0] OP_UNUSED_TOP = 5'd31;

	// idle cycles with no beat taken and no result seen before we give up
	localparam int unsigned STALL_LIMIT = 2000;
	// extra cycles to wait once the queue has drained, before the verdict
	localparam int unsigned DRAIN_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// expected results, oldest first
	rsp_t pending_results[$];
	int unsigned beats_taken = 0;
	int unsigned error_count = 0;
	int unsigned stall_cycles = 0;

	eight_bit_alu_with_flags dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Golden ALU: computes result and Z N H C for one command beat.
	// Integer math on the low bytes, 16-bit only for add16.
	// ------------------------------------------------------------------
	function automatic rsp_t alu_predict(input req_t q);
		int a, b, a16, b16, cy, v;
		logic [7:0] a8;
		logic [3:0] fl;
		logic [15:0] res;
		logic use_z;
		logic cin;
		rsp_t o;
		a8 = q.operand_a[7:0];
		a = q.operand_a[7:0];
		b = q.operand_b[7:0];
		a16 = q.operand_a;
		b16 = q.operand_b;
		cin = q.flags_in[FLAG_C];
		cy = 0;
		v = 0;
		fl = 4'b0000;
		res = 16'h0000;
		use_z = 1'b0;
		case (q.func) inside
		OP_ADD, OP_ADC: begin
			if (q.func == OP_ADC)
				cy = cin;
			v = a + b + cy;
			res = 16'(v & 'hFF);
			use_z = 1'b1;
			fl[FLAG_H] = ((a & 'hF) + (b & 'hF) + cy) > 'hF;
			fl[FLAG_C] = v > 'hFF;
		end
		OP_SUB, OP_SBC, OP_CP: begin
			if (q.func == OP_SBC)
				cy = cin;
			v = (a - b - cy) & 'hFF;
			fl[FLAG_Z] = (v == 0);
			fl[FLAG_N] = 1'b1;
			fl[FLAG_H] = (a & 'hF) < ((b & 'hF) + cy);
			fl[FLAG_C] = a < (b + cy);
			// compare only sets flags, accumulator comes back untouched
			res = (q.func == OP_CP) ? 16'(a) : 16'(v);
		end
		OP_AND: begin
			res = 16'(a & b);
			use_z = 1'b1;
			fl[FLAG_H] = 1'b1;
		end
		OP_XOR: begin
			res = 16'(a ^ b);
			use_z = 1'b1;
		end
		OP_OR: begin
			res = 16'(a | b);
			use_z = 1'b1;
		end
		OP_INC: begin
			res = 16'((a + 1) & 'hFF);
			use_z = 1'b1;
			fl[FLAG_H] = (a & 'hF) == 'hF;
			fl[FLAG_C] = cin;
		end
		OP_DEC: begin
			res = 16'((a - 1) & 'hFF);
			use_z = 1'b1;
			fl[FLAG_N] = 1'b1;
			fl[FLAG_H] = (a & 'hF) == 0;
			fl[FLAG_C] = cin;
		end
		OP_ADD16: begin
			v = a16 + b16;
			res = 16'(v & 'hFFFF);
			fl[FLAG_Z] = q.flags_in[FLAG_Z];
			fl[FLAG_H] = ((a16 & 'hFFF) + (b16 & 'hFFF)) > 'hFFF;
			fl[FLAG_C] = v > 'hFFFF;
		end
		OP_DAA: begin
			v = a;
			cy = cin;
			if (!q.flags_in[FLAG_N]) begin
				if (cy != 0 || v > DAA_MAX) begin
					v = v + DAA_HI;
					cy = 1;
				end
				if (q.flags_in[FLAG_H] || (v & 'hF) > DAA_DIGIT_MAX)
					v = v + DAA_LO;
			end else begin
				if (cy != 0)
					v = v - DAA_HI;
				if (q.flags_in[FLAG_H])
					v = v - DAA_LO;
			end
			res = 16'(v & 'hFF);
			use_z = 1'b1;
			fl[FLAG_N] = q.flags_in[FLAG_N];
			fl[FLAG_C] = cy[0];
		end
		OP_RLC, OP_RLCA: begin
			res = {8'h00, a8[6:0], a8[7]};
			fl[FLAG_C] = a8[7];
		end
		OP_RRC, OP_RRCA: begin
			res = {8'h00, a8[0], a8[7:1]};
			fl[FLAG_C] = a8[0];
		end
		OP_RL, OP_RLA: begin
			res = {8'h00, a8[6:0], cin};
			fl[FLAG_C] = a8[7];
		end
		OP_RR, OP_RRA: begin
			res = {8'h00, cin, a8[7:1]};
			fl[FLAG_C] = a8[0];
		end
		OP_SLA: begin
			res = {8'h00, a8[6:0], 1'b0};
			fl[FLAG_C] = a8[7];
		end
		OP_SRA: begin
			res = {8'h00, a8[7], a8[7:1]};
			fl[FLAG_C] = a8[0];
		end
		OP_SRL: begin
			res = {8'h00, 1'b0, a8[7:1]};
			fl[FLAG_C] = a8[0];
		end
		OP_SWAP: begin
			res = {8'h00, a8[3:0], a8[7:4]};
			use_z = 1'b1;
		end
		OP_BIT: begin
			res = {8'h00, a8};
			fl[FLAG_Z] = ~a8[q.bit_index];
			fl[FLAG_H] = 1'b1;
			fl[FLAG_C] = cin;
		end
		OP_SET: begin
			res = {8'h00, a8 | (8'h01 << q.bit_index)};
			fl = q.flags_in;
		end
		OP_RES: begin
			res = {8'h00, a8 & ~(8'h01 << q.bit_index)};
			fl = q.flags_in;
		end
		default: begin
			res = q.operand_a;
			fl = q.flags_in;
		end
		endcase
		// CB rotates/shifts take Z from the result; the accumulator forms keep Z clear
		if (q.func >= OP_RLC && q.func <= OP_SRL)
			use_z = 1'b1;
		if (use_z)
			fl[FLAG_Z] = (res[7:0] == 8'h00);
		o.result = res;
		o.flags_out = fl;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: sample at the rising edge. Check the result beat first,
	// then queue the prediction for a command beat taken on this edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: result=%h flags_out=%h",
						rsp.result, rsp.flags_out);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.result !== want.result) begin
						$error("result: expected %h, got %h", want.result, rsp.result);
						error_count++;
					end
					if (rsp.flags_out !== want.flags_out) begin
						$error("flags_out: expected %h, got %h", want.flags_out, rsp.flags_out);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				pending_results.push_back(alu_predict(req));
				beats_taken <= beats_taken + 1;
			end
		end
	end

	// Watchdog: no beat taken and no result for too long means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic req_t mk_req(input logic [4:0] f, input logic [15:0] a,
		input logic [15:0] b, input logic [2:0] bi, input logic [3:0] fl);
		req_t q;
		q.func = f;
		q.operand_a = a;
		q.operand_b = b;
		q.bit_index = bi;
		q.flags_in = fl;
		return q;
	endfunction

	// operand word: random, or weighted toward values at nibble, byte and BCD boundaries
	function automatic logic [15:0] rand_word();
		logic [7:0] edges [8];
		edges = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'hFF};
		case ($urandom_range(0, 7)) inside
		0: return 16'hFFFF;
		1: return 16'h0FFF;
		2, 3: return {8'($urandom), edges[$urandom_range(0, 7)]};
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic req_t rand_req();
		logic [4:0] f;
		if ($urandom_range(0, 9) == 0)
			f = 5'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_TOP));
		else
			f = 5'($urandom_range(OP_ADD, OP_RRA));
		return mk_req(f, rand_word(), rand_word(), 3'($urandom), 4'($urandom));
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	// start stays high on return so back-to-back beats never glitch it.
	task automatic send_beat(input req_t item, input int gap);
		int unsigned seen;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) begin
				req = rand_req();	// junk while idle, must be ignored
				@(negedge clk);
			end
		end
		start = 1'b1;
		req = item;
		seen = beats_taken;
		do @(negedge clk); while (beats_taken == seen);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// At least one beat per op, values chosen at the flag boundaries; upper bytes dirty on some 8-bit ops.
	task automatic test_directed_edges();
		req_t edge_items [];
		edge_items = '{
			mk_req(OP_ADD,   16'hABFF, 16'hCD01, 3'd0, 4'h0),	// wraps to zero: Z H C
			mk_req(OP_ADC,   16'h000F, 16'h0000, 3'd0, 4'h1),	// carry-in makes half carry
			mk_req(OP_ADC,   16'h00FF, 16'h0000, 3'd0, 4'h1),
			mk_req(OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'h0),	// full borrow
			mk_req(OP_SBC,   16'h0010, 16'h000F, 3'd0, 4'h1),	// borrow-in reaches zero
			mk_req(OP_SBC,   16'h0000, 16'h00FF, 3'd0, 4'h1),
			mk_req(OP_AND,   16'hFFF0, 16'h000F, 3'd0, 4'hF),
			mk_req(OP_XOR,   16'hFFFF, 16'h00FF, 3'd0, 4'h0),
			mk_req(OP_OR,    16'h0000, 16'h0000, 3'd0, 4'hF),
			mk_req(OP_CP,    16'h1242, 16'h3442, 3'd0, 4'h0),	// equal, returns accumulator
			mk_req(OP_INC,   16'h00FF, 16'h0000, 3'd0, 4'h1),	// carry kept
			mk_req(OP_DEC,   16'h0010, 16'h0000, 3'd0, 4'h0),	// low nibble borrow
			mk_req(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h8),	// Z kept, H and C
			mk_req(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h0),
			mk_req(OP_DAA,   16'h009A, 16'h0000, 3'd0, 4'h0),	// both corrections after add
			mk_req(OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'h7),	// both corrections after sub
			mk_req(OP_RLC,   16'h0080, 16'h0000, 3'd0, 4'h0),
			mk_req(OP_RRC,   16'h0001, 16'h0000, 3'd0, 4'h0),
			mk_req(OP_RL,    16'h0080, 16'h0000, 3'd0, 4'h0),
			mk_req(OP_RR,    16'h0001, 16'h0000, 3'd0, 4'h1),
			mk_req(OP_SLA,   16'h0080, 16'h0000, 3'd0, 4'h0),
			mk_req(OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'h0),
			mk_req(OP_SRL,   16'h0001, 16'h0000, 3'd0, 4'h0),
			mk_req(OP_SWAP,  16'h00F0, 16'h0000, 3'd0, 4'hF),
			mk_req(OP_BIT,   16'h007F, 16'h0000, 3'd7, 4'h1),	// bit clear: Z set
			mk_req(OP_BIT,   16'hFF01, 16'h0000, 3'd0, 4'h0),
			mk_req(OP_SET,   16'hFF00, 16'h0000, 3'd7, 4'hA),
			mk_req(OP_RES,   16'h00FF, 16'h0000, 3'd0, 4'h5),
			mk_req(OP_RLCA,  16'h0000, 16'h0000, 3'd0, 4'hF),	// zero result, Z still clear
			mk_req(OP_RRCA,  16'h0001, 16'h0000, 3'd0, 4'h0),
			mk_req(OP_RLA,   16'h0080, 16'h0000, 3'd0, 4'h1),
			mk_req(OP_RRA,   16'h0000, 16'h0000, 3'd0, 4'h1),
			mk_req(OP_UNUSED_TOP, 16'hBEEF, 16'h1234, 3'd5, 4'h9)	// pass-through
		};
		foreach (edge_items[i])
			send_beat(edge_items[i], pick_gap());
	endtask

	// Random ops with random gaps. After an add/sub, often feed its result and
	// flags into a DAA, as a CPU does for BCD math.
	task automatic test_random_ops(input int count);
		req_t item;
		req_t last_item;
		rsp_t last_rsp;
		last_item = rand_req();
		last_rsp = alu_predict(last_item);
		repeat (count) begin
			if ((last_item.func == OP_ADD || last_item.func == OP_ADC ||
				last_item.func == OP_SUB || last_item.func == OP_SBC) &&
				$urandom_range(0, 2) != 0) begin
				item = mk_req(OP_DAA, {8'($urandom), last_rsp.result[7:0]}, rand_word(),
					3'($urandom), last_rsp.flags_out);
			end else begin
				item = rand_req();
			end
			send_beat(item, pick_gap());
			last_item = item;
			last_rsp = alu_predict(item);
		end
	endtask

	// Full rate: a beat on every clock.
	task automatic test_back_to_back(input int count);
		repeat (count)
			send_beat(rand_req(), 0);
	endtask

	// Sender holds off until every queued result is back, then resumes.
	task automatic test_drain_pause(input int burst);
		repeat (burst)
			send_beat(rand_req(), pick_gap());
		wait_drained();
		repeat (burst)
			send_beat(rand_req(), pick_gap());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_edges();
		test_random_ops(400);
		test_back_to_back(50);
		test_drain_pause(12);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
src/ebalu_pkg.sv
src/ebalu_core.sv
src/eight_bit_alu_with_flags.sv
tb/eight_bit_alu_with_flags_tb.sv
